// ----- src/bcdce_pkg.sv -----
`default_nettype none

package bcdce_pkg;

  typedef enum logic [1:0] {
    OP_LEFT  = 2'd0,
    OP_RIGHT = 2'd1,
    OP_INC   = 2'd2,
    OP_DEC   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    POS_HOME    = 4'd0,
    POS_YEAR    = 4'd1,
    POS_MONTH   = 4'd2,
    POS_DATE    = 4'd3,
    POS_WEEKDAY = 4'd4,
    POS_AMPM    = 4'd5,
    POS_HOUR    = 4'd6,
    POS_MINUTE  = 4'd7,
    POS_SECOND  = 4'd8
  } pos_e;

  // Clock register map
  localparam logic [2:0] REG_SEC     = 3'd0;
  localparam logic [2:0] REG_MIN     = 3'd1;
  localparam logic [2:0] REG_HOUR    = 3'd2;
  localparam logic [2:0] REG_WEEKDAY = 3'd3;
  localparam logic [2:0] REG_DATE    = 3'd4;
  localparam logic [2:0] REG_MONTH   = 3'd5;
  localparam logic [2:0] REG_YEAR    = 3'd6;

  // Field bounds, BCD
  localparam logic [7:0] MINSEC_MAX = 8'h59;
  localparam logic [7:0] YEAR_MAX   = 8'h99;
  localparam logic [7:0] MONTH_MAX  = 8'h12;
  localparam logic [7:0] DATE_MAX   = 8'h31;
  localparam logic [7:0] WDAY_MAX   = 8'h07;
  localparam logic [7:0] HOUR_MODE  = 8'hE0;
  localparam logic [7:0] HOUR_DIGS  = 8'h1F;
  localparam logic [7:0] AMPM_BIT   = 8'h20;

endpackage

`default_nettype wire

// ----- src/bcdce_ifs.sv -----
`default_nettype none

interface bcdce_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] current_value;

  modport source (output valid, output operation, output current_value, input ready);
  modport sink   (input valid, input operation, input current_value, output ready);
endinterface

interface bcdce_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] cursor_pos;
  logic       field_selected;
  logic [2:0] register_address;
  logic       write_enable;
  logic [7:0] write_value;

  modport source (output valid, output cursor_pos, output field_selected,
                  output register_address, output write_enable, output write_value,
                  input ready);
  modport sink   (input valid, input cursor_pos, input field_selected,
                  input register_address, input write_enable, input write_value,
                  output ready);
endinterface

`default_nettype wire

// ----- src/bcd_clock_field_editor_unit.sv -----
`default_nettype none
// BCD clock setting editor: cursor ring plus per-field BCD edit.
// Result is registered: it is valid in the cycle after a request is accepted.
// Throughput: one request per cycle; a request is taken while the held result
// is being consumed, ready drops only while an untaken result sits in the register.
// Reset (rst_ni low, asynchronous): cursor to home, result register empty.

module bcd_clock_field_editor_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  bcdce_req_if.sink          req_i,
  bcdce_rsp_if.source        rsp_o
);
  import bcdce_pkg::*;

  pos_e       cursor_q, cursor_d;
  pos_e       pos_cur;
  op_e        op;
  logic       fire;
  logic       edit;
  logic [7:0] edit_val;

  logic       rsp_valid_q;
  pos_e       rsp_pos_q;
  logic       rsp_sel_q;
  logic [2:0] rsp_addr_q;
  logic       rsp_we_q;
  logic [7:0] rsp_wv_q;

  // Clock register behind each cursor position; AM/PM edits the hour register
  function automatic logic [2:0] reg_of_pos(input pos_e p);
    unique case (p)
      POS_YEAR:    return REG_YEAR;
      POS_MONTH:   return REG_MONTH;
      POS_DATE:    return REG_DATE;
      POS_WEEKDAY: return REG_WEEKDAY;
      POS_AMPM,
      POS_HOUR:    return REG_HOUR;
      POS_MINUTE:  return REG_MIN;
      POS_SECOND:  return REG_SEC;
      default:     return REG_SEC;
    endcase
  endfunction

  // Output register frees up when empty or being drained this cycle
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;
  assign op          = op_e'(req_i.operation);

  // Unreachable cursor codes fall back to home
  assign pos_cur = (cursor_q > POS_SECOND) ? POS_HOME : cursor_q;

  always_comb begin
    cursor_d = pos_cur;
    edit     = 1'b0;
    unique case (op)
      OP_LEFT:  cursor_d = (pos_cur == POS_HOME) ? POS_SECOND : pos_e'(pos_cur - 4'd1);
      OP_RIGHT: cursor_d = (pos_cur == POS_SECOND) ? POS_HOME : pos_e'(pos_cur + 4'd1);
      default:  edit     = (pos_cur != POS_HOME);
    endcase
  end

  // Edit works on the position before the step; moves never change it anyway
  bcdce_edit u_edit (
    .pos_i   (pos_cur),
    .up_i    (op == OP_INC),
    .value_i (req_i.current_value),
    .value_o (edit_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= POS_HOME;
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      cursor_q    <= cursor_d;
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_pos_q  <= cursor_d;
      rsp_sel_q  <= (cursor_d != POS_HOME);
      rsp_addr_q <= reg_of_pos(cursor_d);
      rsp_we_q   <= edit;
      rsp_wv_q   <= edit ? edit_val : 8'h00;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.cursor_pos       = rsp_pos_q;
  assign rsp_o.field_selected   = rsp_sel_q;
  assign rsp_o.register_address = rsp_addr_q;
  assign rsp_o.write_enable     = rsp_we_q;
  assign rsp_o.write_value      = rsp_wv_q;

endmodule

`default_nettype wire

// ----- src/bcdce_edit.sv -----
`default_nettype none

// Field edit: one increment or decrement, wrapped per field (BCD; weekday counts in binary, AM/PM toggles its bit).
module bcdce_edit (
  input  bcdce_pkg::pos_e pos_i,
  input  logic            up_i,
  input  logic [7:0]      value_i,
  output logic [7:0]      value_o
);
  import bcdce_pkg::*;

  // BCD -> binary (mod 256), +/-1, binary -> BCD; /10 by reciprocal 205/2048
  function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic up);
    logic [7:0]  b;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    b    = 8'({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
    b    = up ? b + 8'd1 : b - 8'd1;
    prod = 16'(b) * 16'd205;
    q    = prod[15:11];
    r    = b - 8'({3'd0, q} * 8'd10);
    return 8'({q, 4'd0} + {1'b0, r});
  endfunction

  function automatic logic [7:0] wrap(input logic [7:0] v, input logic up,
                                      input logic [7:0] lo, input logic [7:0] hi);
    if (up) return (v == hi) ? lo : bcd_step(v, 1'b1);
    return (v == lo) ? hi : bcd_step(v, 1'b0);
  endfunction

  always_comb begin
    case (pos_i)
      POS_AMPM:   value_o = value_i ^ AMPM_BIT;
      POS_HOUR: begin
        if (up_i)
          value_o = ((value_i & HOUR_DIGS) == 8'h12) ? (value_i & HOUR_MODE) + 8'h01
                                                      : bcd_step(value_i, 1'b1);
        else
          value_o = ((value_i & HOUR_DIGS) == 8'h01) ? (value_i & HOUR_MODE) + 8'h12
                                                      : bcd_step(value_i, 1'b0);
      end
      POS_MINUTE,
      POS_SECOND: value_o = wrap(value_i, up_i, 8'h00, MINSEC_MAX);
      POS_YEAR:   value_o = wrap(value_i, up_i, 8'h00, YEAR_MAX);
      POS_MONTH:  value_o = wrap(value_i, up_i, 8'h01, MONTH_MAX);
      POS_DATE:   value_o = wrap(value_i, up_i, 8'h01, DATE_MAX);
      POS_WEEKDAY: begin
        // binary count, not BCD
        if (up_i) value_o = (value_i == WDAY_MAX) ? 8'h01 : value_i + 8'd1;
        else      value_o = (value_i == 8'h01) ? WDAY_MAX : value_i - 8'd1;
      end
      default:    value_o = 8'h00;
    endcase
  end

endmodule

`default_nettype wire
